>>> sv/falu_pkg.sv
// Package for the fixed-point ALU: opcode encoding and the side-band record
// that travels with each operation down the divider chain. No dependencies.
`default_nettype none

package falu_pkg;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_LT       = 4'd4,
    OP_LE       = 4'd5,
    OP_GT       = 4'd6,
    OP_GE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } op_t;

  localparam int unsigned WORD_W = 32;

  typedef struct packed {
    op_t                op;
    logic [WORD_W-1:0]  res;
    logic               cmp;
    logic               dz;
    logic               neg;
  } side_t;

endpackage

`default_nettype wire

>>> sv/falu_req_if.sv
// Request channel of the fixed-point ALU: opcode and two raw operands.
// Uses valid/ready; no other dependencies.
`default_nettype none

interface falu_req_if;
  logic               valid;
  logic               ready;
  logic [3:0]         req_type;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;

  modport source (output valid, req_type, operand_a, operand_b, input ready);
  modport sink (input valid, req_type, operand_a, operand_b, output ready);
endinterface

`default_nettype wire

>>> sv/falu_rsp_if.sv
// Response channel of the fixed-point ALU: raw result and two flags.
// Uses valid/ready; no other dependencies.
`default_nettype none

interface falu_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_raw;
  logic               compare_true;
  logic               divide_by_zero;

  modport source (output valid, result_raw, compare_true, divide_by_zero, input ready);
  modport sink (input valid, result_raw, compare_true, divide_by_zero, output ready);
endinterface

`default_nettype wire

>>> sv/falu_front.sv
// Entry stage of the fixed-point ALU: evaluates every non-divide operation
// and prepares the divider operands. Depends on falu_pkg and falu_req_if.
`default_nettype none

module falu_front
  import falu_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  falu_req_if.sink                req,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [WORD_W+FRAC_BITS-1:0] out_dvd,
  output logic [WORD_W-1:0]       out_dvs,
  output side_t                   out_side
);

  localparam int unsigned DVD_W = WORD_W + FRAC_BITS;
  localparam logic [WORD_W-1:0] DZ_RES = (32'h7FFF_FFFF >> FRAC_BITS) << FRAC_BITS;

  logic               valid;
  logic [DVD_W-1:0]   dvd;
  logic [WORD_W-1:0]  dvs;
  side_t              side;

  logic [WORD_W-1:0]  a;
  logic [WORD_W-1:0]  b;
  logic               a_lt_b;
  logic               b_lt_a;
  logic signed [63:0] prod;
  logic signed [63:0] prod_sh;
  logic [WORD_W-1:0]  mag_a;
  logic [WORD_W-1:0]  mag_b;
  side_t              side_next;
  logic               take;

  assign a       = req.operand_a;
  assign b       = req.operand_b;
  assign a_lt_b  = $signed(a) < $signed(b);
  assign b_lt_a  = $signed(b) < $signed(a);
  assign prod    = $signed(a) * $signed(b);
  assign prod_sh = prod >>> FRAC_BITS;
  assign mag_a   = a[WORD_W-1] ? (32'd0 - a) : a;
  assign mag_b   = b[WORD_W-1] ? (32'd0 - b) : b;

  always_comb begin
    side_next     = '0;
    side_next.op  = op_t'(req.req_type);
    side_next.neg = a[WORD_W-1] ^ b[WORD_W-1];
    case (op_t'(req.req_type))
      OP_ADD:      side_next.res = a + b;
      OP_SUB:      side_next.res = a - b;
      OP_MUL:      side_next.res = prod_sh[WORD_W-1:0];
      OP_DIV: begin
        if (b == '0) begin
          side_next.res = DZ_RES;
          side_next.dz  = 1'b1;
        end
      end
      OP_LT:       side_next.cmp = a_lt_b;
      OP_LE:       side_next.cmp = !b_lt_a;
      OP_GT:       side_next.cmp = b_lt_a;
      OP_GE:       side_next.cmp = !a_lt_b;
      OP_EQ:       side_next.cmp = (a == b);
      OP_NE:       side_next.cmp = (a != b);
      OP_MIN:      side_next.res = a_lt_b ? a : b;
      OP_MAX:      side_next.res = b_lt_a ? a : b;
      OP_INC:      side_next.res = a + 32'd1;
      OP_DEC:      side_next.res = a - 32'd1;
      OP_FROM_INT: side_next.res = a << FRAC_BITS;
      OP_TO_INT:   side_next.res = WORD_W'($signed(a) >>> FRAC_BITS);
      default:     side_next.res = '0;
    endcase
  end

  assign req.ready = !valid || out_ready;
  assign take      = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (req.ready) begin
      valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dvd  <= {mag_a, {FRAC_BITS{1'b0}}};
      dvs  <= mag_b;
      side <= side_next;
    end
  end

  assign out_valid = valid;
  assign out_dvd   = dvd;
  assign out_dvs   = dvs;
  assign out_side  = side;

endmodule

`default_nettype wire

>>> sv/falu_cell.sv
// One restoring-division cell: develops one quotient bit per transfer and
// forwards the side-band record unchanged. Depends on falu_pkg.
`default_nettype none

module falu_cell
  import falu_pkg::*;
#(
  parameter int unsigned DVD_W = 40
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [WORD_W-1:0] in_rem,
  input  wire logic [DVD_W-1:0]  in_dvd,
  input  wire logic [WORD_W-1:0] in_dvs,
  input  wire side_t             in_side,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [WORD_W-1:0]      out_rem,
  output logic [DVD_W-1:0]       out_dvd,
  output logic [WORD_W-1:0]      out_dvs,
  output side_t                  out_side
);

  logic               valid;
  logic [WORD_W-1:0]  rem;
  logic [DVD_W-1:0]   dvd;
  logic [WORD_W-1:0]  dvs;
  side_t              side;

  logic [WORD_W+1:0]  diff;
  logic               fits;
  logic [WORD_W-1:0]  rem_next;
  logic [DVD_W-1:0]   dvd_next;

  // The partial remainder stays below the divisor, so the shifted value
  // needs one extra bit and the trial subtraction one more for the borrow.
  assign diff     = {1'b0, in_rem, in_dvd[DVD_W-1]} - {2'b00, in_dvs};
  assign fits     = !diff[WORD_W+1];
  assign rem_next = fits ? diff[WORD_W-1:0] : {in_rem[WORD_W-2:0], in_dvd[DVD_W-1]};
  assign dvd_next = {in_dvd[DVD_W-2:0], fits};

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rem  <= rem_next;
      dvd  <= dvd_next;
      dvs  <= in_dvs;
      side <= in_side;
    end
  end

  assign out_valid = valid;
  assign out_rem   = rem;
  assign out_dvd   = dvd;
  assign out_dvs   = dvs;
  assign out_side  = side;

endmodule

`default_nettype wire

>>> sv/falu_back.sv
// Output stage of the fixed-point ALU: applies the sign to the quotient and
// holds the result for the response channel. Depends on falu_pkg, falu_rsp_if.
`default_nettype none

module falu_back
  import falu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [WORD_W-1:0] in_quot,
  input  wire side_t             in_side,
  falu_rsp_if.source             rsp
);

  logic               valid;
  logic [WORD_W-1:0]  res;
  logic               cmp;
  logic               dz;
  logic [WORD_W-1:0]  res_next;

  always_comb begin
    if (in_side.op == OP_DIV && !in_side.dz) begin
      res_next = in_side.neg ? (32'd0 - in_quot) : in_quot;
    end else begin
      res_next = in_side.res;
    end
  end

  assign in_ready = !valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res <= res_next;
      cmp <= in_side.cmp;
      dz  <= in_side.dz;
    end
  end

  assign rsp.valid          = valid;
  assign rsp.result_raw     = res;
  assign rsp.compare_true   = cmp;
  assign rsp.divide_by_zero = dz;

endmodule

`default_nettype wire

>>> sv/fixed_point_alu.sv
// Fixed-point ALU on 32-bit signed raw values with FRAC_BITS fraction bits.
// Instantiates falu_front, a row of falu_cell and falu_back; uses falu_pkg.
//
// Usage: operations arrive on the req channel (opcode, operand_a, operand_b)
// and each gives exactly one transfer on the rsp channel, in issue order.
// Every operation, divide or not, runs down the same pipeline: one entry
// stage, a row of 32 + FRAC_BITS division cells that each develop one
// quotient bit, and one output register.
// Throughput is one operation per cycle while the receiver does not stall.
// Each stage has its own valid bit and accepts new data when empty or when
// its successor takes its contents, so when the receiver stalls the results
// pile up from the output backwards and bubbles are squeezed out; req.ready
// drops only when every stage is full. A synchronous reset empties all
// stages; nothing else needs clearing.
`default_nettype none

module fixed_point_alu
  import falu_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire logic  clk,
  input  wire logic  rst,
  falu_req_if.sink   req,
  falu_rsp_if.source rsp
);

  localparam int unsigned DVD_W  = WORD_W + FRAC_BITS;
  localparam int unsigned NCELLS = DVD_W;

  logic               vld_c [0:NCELLS];
  logic               rdy_c [0:NCELLS];
  logic [WORD_W-1:0]  rem_c [0:NCELLS];
  logic [DVD_W-1:0]   dvd_c [0:NCELLS];
  logic [WORD_W-1:0]  dvs_c [0:NCELLS];
  side_t              side_c [0:NCELLS];

  falu_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .out_valid (vld_c[0]),
    .out_ready (rdy_c[0]),
    .out_dvd   (dvd_c[0]),
    .out_dvs   (dvs_c[0]),
    .out_side  (side_c[0])
  );

  assign rem_c[0] = '0;

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    falu_cell #(
      .DVD_W (DVD_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld_c[i]),
      .in_ready  (rdy_c[i]),
      .in_rem    (rem_c[i]),
      .in_dvd    (dvd_c[i]),
      .in_dvs    (dvs_c[i]),
      .in_side   (side_c[i]),
      .out_valid (vld_c[i+1]),
      .out_ready (rdy_c[i+1]),
      .out_rem   (rem_c[i+1]),
      .out_dvd   (dvd_c[i+1]),
      .out_dvs   (dvs_c[i+1]),
      .out_side  (side_c[i+1])
    );
  end

  falu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vld_c[NCELLS]),
    .in_ready (rdy_c[NCELLS]),
    .in_quot  (dvd_c[NCELLS][WORD_W-1:0]),
    .in_side  (side_c[NCELLS]),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire
